FILE: design/tafa_pkg.sv
// ----------------------------------------------------------------------------
// tafa_pkg
// Shared types and constants of the t-SNE attractive force accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tafa_pkg;

  localparam int unsigned NumDims  = 3;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned MagW     = 33;
  localparam int unsigned AffW     = 32;
  localparam int unsigned ExagW    = 24;
  localparam int unsigned GradW    = 48;
  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned Dist2W   = 50;
  localparam int unsigned QuoW     = 33;
  localparam int unsigned QW       = 32;
  localparam int unsigned PeW      = 41;
  localparam int unsigned TermW    = 42;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [Dist2W-1:0] KernelOne = Dist2W'(65536);
  localparam logic [Dist2W-1:0] DivInit   = Dist2W'(32768);
  localparam logic [ExagW-1:0]  ExagReset = ExagW'(65536);
  localparam logic [1:0]        DimsReset = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgExaggeration = 2'd0,
    CfgDims         = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic              en;
    logic [MulW-1:0]   a;
    logic [MulW-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [Dist2W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [QuoW-1:0]   quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: design/tafa_mul.sv
// ----------------------------------------------------------------------------
// tafa_mul
// Shared unsigned 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tafa_mul (
  input  wire logic                  clk_i,
  input  wire tafa_pkg::mul_req_t    req_i,
  output logic [tafa_pkg::ProdW-1:0] prod_o
);

  logic [tafa_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= tafa_pkg::ProdW'(req_i.a) * tafa_pkg::ProdW'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: design/tafa_div.sv
// ----------------------------------------------------------------------------
// tafa_div
// Radix-2 restoring divider that forms 2^48 / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tafa_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tafa_pkg::div_req_t req_i,
  output tafa_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(tafa_pkg::QuoW);

  logic                          busy_q, busy_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [tafa_pkg::Dist2W-1:0]   rem_q, rem_d;
  logic [tafa_pkg::Dist2W-1:0]   den_q, den_d;
  logic [tafa_pkg::QuoW-1:0]     quo_q, quo_d;
  logic [tafa_pkg::Dist2W:0]     shifted;
  logic [tafa_pkg::Dist2W:0]     diff;
  logic                          fits;

  always_comb begin
    shifted = {rem_q, 1'b0};
    diff    = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = tafa_pkg::DivInit;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[tafa_pkg::Dist2W-1:0] : shifted[tafa_pkg::Dist2W-1:0];
      quo_d = {quo_q[tafa_pkg::QuoW-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(tafa_pkg::QuoW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: design/tsne_attractive_force_accumulator.sv
// ----------------------------------------------------------------------------
// tsne_attractive_force_accumulator
// Accumulates the Student-t attractive gradient of one point over its neighbors.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   own_*, nbr_*, affinity, flags
// out      output     out_valid_o / out_ready_i grad_x, grad_y, grad_z
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A request with a neighbor is sequenced by the shared multiplier (three
// products per dimension) and the 33-step reciprocal divider. A request
// without a neighbor goes straight to the end step.
// After reset the accumulators are zero, exaggeration is 1.0 and dims is 2.
// A finished gradient waits in an output register; the next request is taken
// meanwhile, and only a second gradient waits for the first to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tsne_attractive_force_accumulator #(
  parameter int unsigned MAX_DIMS = 3
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [tafa_pkg::CoordW-1:0]    own_x_i,
  input  wire logic signed [tafa_pkg::CoordW-1:0]    own_y_i,
  input  wire logic signed [tafa_pkg::CoordW-1:0]    own_z_i,
  input  wire logic signed [tafa_pkg::CoordW-1:0]    nbr_x_i,
  input  wire logic signed [tafa_pkg::CoordW-1:0]    nbr_y_i,
  input  wire logic signed [tafa_pkg::CoordW-1:0]    nbr_z_i,
  input  wire logic [tafa_pkg::AffW-1:0]             affinity_i,
  input  wire logic                                  has_neighbor_i,
  input  wire logic                                  first_i,
  input  wire logic                                  last_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [tafa_pkg::GradW-1:0]         grad_x_o,
  output logic signed [tafa_pkg::GradW-1:0]         grad_y_o,
  output logic signed [tafa_pkg::GradW-1:0]         grad_z_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [tafa_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire logic [tafa_pkg::CfgDataW-1:0]         cfg_data_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSq   = 4'd1;
  localparam logic [3:0] StSqA  = 4'd2;
  localparam logic [3:0] StPe   = 4'd3;
  localparam logic [3:0] StDiv  = 4'd4;
  localparam logic [3:0] StW0   = 4'd5;
  localparam logic [3:0] StW1   = 4'd6;
  localparam logic [3:0] StW2   = 4'd7;
  localparam logic [3:0] StT0   = 4'd8;
  localparam logic [3:0] StT1   = 4'd9;
  localparam logic [3:0] StT2   = 4'd10;
  localparam logic [3:0] StEnd  = 4'd11;

  localparam int unsigned GW = tafa_pkg::GradW;
  localparam logic signed [GW:0] AccMax = {2'b00, {(GW - 1){1'b1}}};
  localparam logic signed [GW:0] AccMin = {2'b11, {(GW - 1){1'b0}}};

  logic [3:0]                        state_q, state_d;
  logic [1:0]                        dim_q, dim_d;
  logic [1:0]                        nd_q, nd_d;
  logic [1:0]                        nd_in;
  logic                              last_q, last_d;
  logic [tafa_pkg::ExagW-1:0]        exag_q, exag_d;
  logic [1:0]                        dims_q, dims_d;
  logic [tafa_pkg::MagW-1:0]         mag_q [tafa_pkg::NumDims];
  logic [tafa_pkg::MagW-1:0]         mag_d [tafa_pkg::NumDims];
  logic                              neg_q [tafa_pkg::NumDims];
  logic                              neg_d [tafa_pkg::NumDims];
  logic signed [GW-1:0]              acc_q [tafa_pkg::NumDims];
  logic signed [GW-1:0]              acc_d [tafa_pkg::NumDims];
  logic signed [GW-1:0]              grad_q [tafa_pkg::NumDims];
  logic signed [GW-1:0]              grad_d [tafa_pkg::NumDims];
  logic                              out_valid_q, out_valid_d;
  logic [tafa_pkg::AffW-1:0]         aff_q, aff_d;
  logic [tafa_pkg::Dist2W-1:0]       d2_q, d2_d;
  logic [tafa_pkg::PeW-1:0]          pe_q, pe_d;
  logic [tafa_pkg::PeW-1:0]          w_q, w_d;
  logic [tafa_pkg::MagW-1:0]         tmp_q, tmp_d;
  logic signed [tafa_pkg::CoordW:0]  diff [tafa_pkg::NumDims];
  logic signed [tafa_pkg::CoordW-1:0] own [tafa_pkg::NumDims];
  logic signed [tafa_pkg::CoordW-1:0] nbr [tafa_pkg::NumDims];
  logic [tafa_pkg::QW-1:0]           q_sat;
  logic [tafa_pkg::TermW-1:0]        term;
  logic signed [GW:0]                delta;
  logic signed [GW:0]                sum;
  logic [tafa_pkg::ProdW-1:0]        prod;
  logic                              in_acc;
  logic                              out_load;
  tafa_pkg::mul_req_t                mul_req;
  tafa_pkg::div_req_t                div_req;
  tafa_pkg::div_rsp_t                div_rsp;

  tafa_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  tafa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign own = '{own_x_i, own_y_i, own_z_i};
  assign nbr = '{nbr_x_i, nbr_y_i, nbr_z_i};

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign nd_in = (dims_q == 2'd0) ? 2'd1 :
                 (dims_q > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : dims_q;

  assign q_sat = div_rsp.quotient[tafa_pkg::QuoW-1] ? '1
                                                    : div_rsp.quotient[tafa_pkg::QW-1:0];
  assign term  = tafa_pkg::TermW'(tmp_q) + prod[tafa_pkg::TermW-1:0];
  assign delta = neg_q[dim_q] ? (GW + 1)'(0) - (GW + 1)'(term) : (GW + 1)'(term);
  assign sum   = {acc_q[dim_q][GW-1], acc_q[dim_q]} + delta;

  always_comb begin
    mul_req = '0;
    unique case (state_q)
      StSq: begin
        mul_req = '{en: 1'b1, a: mag_q[dim_q], b: mag_q[dim_q]};
      end
      StPe: begin
        mul_req = '{en: 1'b1, a: tafa_pkg::MulW'(aff_q), b: tafa_pkg::MulW'(exag_q)};
      end
      StW0: begin
        mul_req = '{en: 1'b1, a: tafa_pkg::MulW'(pe_q[31:0]), b: tafa_pkg::MulW'(q_sat)};
      end
      StW1: begin
        mul_req = '{en: 1'b1, a: tafa_pkg::MulW'(pe_q[tafa_pkg::PeW-1:32]),
                    b: tafa_pkg::MulW'(q_sat)};
      end
      StT0: begin
        mul_req = '{en: 1'b1, a: tafa_pkg::MulW'(w_q[31:0]), b: mag_q[dim_q]};
      end
      StT1: begin
        mul_req = '{en: 1'b1, a: tafa_pkg::MulW'(w_q[tafa_pkg::PeW-1:32]), b: mag_q[dim_q]};
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  assign div_req.start   = (state_q == StPe);
  assign div_req.divisor = tafa_pkg::KernelOne + d2_q;

  assign out_load = (state_q == StEnd) && last_q && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    dim_d       = dim_q;
    nd_d        = nd_q;
    last_d      = last_q;
    exag_d      = exag_q;
    dims_d      = dims_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    grad_d      = grad_q;
    out_valid_d = out_valid_q;
    aff_d       = aff_q;
    d2_d        = d2_q;
    pe_d        = pe_q;
    w_d         = w_q;
    tmp_d       = tmp_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tafa_pkg::CfgExaggeration: exag_d = cfg_data_i;
        tafa_pkg::CfgDims:         dims_d = cfg_data_i[1:0];
        default:                   ;
      endcase
    end

    if (out_valid_o && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    for (int k = 0; k < tafa_pkg::NumDims; k++) begin
      diff[k] = {own[k][tafa_pkg::CoordW-1], own[k]} - {nbr[k][tafa_pkg::CoordW-1], nbr[k]};
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          nd_d   = nd_in;
          last_d = last_i;
          aff_d  = affinity_i;
          d2_d   = '0;
          dim_d  = '0;
          for (int k = 0; k < tafa_pkg::NumDims; k++) begin
            neg_d[k] = diff[k][tafa_pkg::CoordW];
            mag_d[k] = diff[k][tafa_pkg::CoordW] ? tafa_pkg::MagW'(0) - diff[k] : diff[k];
            if (first_i) begin
              acc_d[k] = '0;
            end
          end
          state_d = has_neighbor_i ? StSq : StEnd;
        end
      end
      StSq: begin
        state_d = StSqA;
      end
      StSqA: begin
        d2_d = d2_q + prod[tafa_pkg::ProdW-1:16];
        if (dim_q == nd_q - 2'd1) begin
          dim_d   = '0;
          state_d = StPe;
        end else begin
          dim_d   = dim_q + 2'd1;
          state_d = StSq;
        end
      end
      StPe: begin
        state_d = StDiv;
      end
      StDiv: begin
        pe_d = prod[tafa_pkg::PeW+14:15];
        if (!div_rsp.busy) begin
          state_d = StW0;
        end
      end
      StW0: begin
        state_d = StW1;
      end
      StW1: begin
        w_d     = tafa_pkg::PeW'(prod[63:32]);
        state_d = StW2;
      end
      StW2: begin
        w_d     = w_q + prod[tafa_pkg::PeW-1:0];
        state_d = StT0;
      end
      StT0: begin
        state_d = StT1;
      end
      StT1: begin
        tmp_d   = prod[64:32];
        state_d = StT2;
      end
      StT2: begin
        if (sum[GW] != sum[GW-1]) begin
          acc_d[dim_q] = sum[GW] ? AccMin[GW-1:0] : AccMax[GW-1:0];
        end else begin
          acc_d[dim_q] = sum[GW-1:0];
        end
        if (dim_q == nd_q - 2'd1) begin
          state_d = StEnd;
        end else begin
          dim_d   = dim_q + 2'd1;
          state_d = StT0;
        end
      end
      StEnd: begin
        if (!last_q) begin
          state_d = StIdle;
        end else if (out_load) begin
          for (int k = 0; k < tafa_pkg::NumDims; k++) begin
            grad_d[k] = (2'(k) < nd_q) ? acc_q[k] : '0;
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      dim_q       <= '0;
      nd_q        <= 2'd1;
      last_q      <= 1'b0;
      exag_q      <= tafa_pkg::ExagReset;
      dims_q      <= tafa_pkg::DimsReset;
      out_valid_q <= 1'b0;
      for (int k = 0; k < tafa_pkg::NumDims; k++) begin
        acc_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      dim_q       <= dim_d;
      nd_q        <= nd_d;
      last_q      <= last_d;
      exag_q      <= exag_d;
      dims_q      <= dims_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    grad_q <= grad_d;
    aff_q  <= aff_d;
    d2_q   <= d2_d;
    pe_q   <= pe_d;
    w_q    <= w_d;
    tmp_q  <= tmp_d;
  end

  assign out_valid_o = out_valid_q;
  assign grad_x_o    = grad_q[0];
  assign grad_y_o    = grad_q[1];
  assign grad_z_o    = grad_q[2];

  // The divider only runs while the sequencer waits on it.
  a_div_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == StDiv))
    else $error("divider busy outside the divide step");

  // The dimension counter stays within the active dimensions.
  a_dim_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle && state_q != StEnd) |-> (dim_q < nd_q))
    else $error("dimension counter out of range");

  // A request that opens a row clears all accumulators.
  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && first_i) |=> (acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0))
    else $error("accumulators not cleared on first request");

  // A gradient is loaded only when the output register is free or being taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> out_ready_i)
    else $error("pending gradient overwritten");

endmodule

`default_nettype wire
